@@ design/ffpra_pkg.sv @@
// Package for the first-fit page region allocator.
// Holds defaults, operation and status codes, the state type and the cell control struct.
// No dependencies.
`default_nettype none
package ffpra_pkg;

    localparam int TABLE_DEPTH_DEF      = 16;
    localparam int PAGE_NUMBER_BITS_DEF = 52;
    localparam int COUNT_BITS           = 32;

    typedef enum logic [1:0] {
        FUNC_INIT  = 2'd0,
        FUNC_ALLOC = 2'd1,
        FUNC_MARK  = 2'd2,
        FUNC_RSVD  = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_NOFIT = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_APPLY,
        S_OUT
    } state_t;

    typedef struct packed {
        logic search;
        logic is_alloc;
        logic init;
        logic remove;
        logic cut;
        logic split;
    } cell_ctl_t;

endpackage
`default_nettype wire

@@ design/ffpra_cell.sv @@
// One table cell: holds one free region, compares it against the request and
// updates itself, taking its upper neighbour's entry when the table closes up.
// Depends on ffpra_pkg.
`default_nettype none
module ffpra_cell #(
    parameter int PB = ffpra_pkg::PAGE_NUMBER_BITS_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire ffpra_pkg::cell_ctl_t           ctl,
    input  wire logic                           in_use,
    input  wire logic                           head,
    input  wire logic                           sel,
    input  wire logic                           shift,
    input  wire logic                           append,
    input  wire logic [PB-1:0]                  req_base,
    input  wire logic [ffpra_pkg::COUNT_BITS-1:0] req_count,
    input  wire logic [PB-1:0]                  pool_base,
    input  wire logic [ffpra_pkg::COUNT_BITS-1:0] pool_pages,
    input  wire logic [PB-1:0]                  nxt_base,
    input  wire logic [ffpra_pkg::COUNT_BITS-1:0] nxt_pages,
    input  wire logic [ffpra_pkg::COUNT_BITS-1:0] app_pages,
    output logic      [PB-1:0]                  base,
    output logic      [ffpra_pkg::COUNT_BITS-1:0] pages,
    output logic                                hit,
    output logic                                exact,
    output logic      [ffpra_pkg::COUNT_BITS-1:0] rem
);
    localparam int CB = ffpra_pkg::COUNT_BITS;
    localparam int SW = ((PB > CB) ? PB : CB) + 1;

    logic [PB-1:0] base_reg;
    logic [CB-1:0] pages_reg;
    logic          hit_reg;
    logic          exact_reg;
    logic [CB-1:0] rem_reg;
    logic [CB-1:0] lo_reg;
    logic [SW-1:0] nend;
    logic [SW-1:0] rend;
    logic [SW-1:0] cut_sum;
    logic          contain;
    logic          whole;

    always_comb
    begin
        nend    = SW'(base_reg) + SW'(pages_reg);
        rend    = SW'(req_base) + SW'(req_count);
        cut_sum = SW'(base_reg) + SW'(req_count);
        contain = (req_base >= base_reg) && (rend <= nend);
        whole   = (req_base == base_reg) && (rend == nend);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg   <= 1'b0;
            exact_reg <= 1'b0;
        end
        else if (ctl.search)
        begin
            hit_reg   <= in_use && (ctl.is_alloc ? (pages_reg >= req_count) : contain);
            exact_reg <= ctl.is_alloc ? (pages_reg == req_count) : whole;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.search)
        begin
            rem_reg <= CB'(nend - rend);
            lo_reg  <= CB'(SW'(req_base) - SW'(base_reg));
        end
        if (ctl.init && head)
        begin
            base_reg  <= pool_base;
            pages_reg <= pool_pages;
        end
        else if (ctl.remove && shift)
        begin
            base_reg  <= nxt_base;
            pages_reg <= nxt_pages;
        end
        else if (ctl.cut && sel)
        begin
            base_reg  <= cut_sum[PB-1:0];
            pages_reg <= pages_reg - req_count;
        end
        else if (ctl.split && sel)
        begin
            pages_reg <= lo_reg;
        end
        else if (ctl.split && append)
        begin
            base_reg  <= rend[PB-1:0];
            pages_reg <= app_pages;
        end
    end

    assign base  = base_reg;
    assign pages = pages_reg;
    assign hit   = hit_reg;
    assign exact = exact_reg;
    assign rem   = rem_reg;
endmodule
`default_nettype wire

@@ design/first_fit_page_region_allocator_top.sv @@
// Top level of the first-fit page region allocator: stream ports, APB registers,
// sequencer and the row of ffpra_cell entries. Depends on ffpra_pkg, ffpra_cell.
//
//  channel  | direction | payload
//  s_*      | in        | tuser: func; tdata: page_count, base_page
//  m_*      | out       | tuser: status; tdata: page_base
//  APB      | in/out    | pool_base_page at 0x0, pool_pages at 0x8
//
// Each item passes through accept, search (every cell compares at once),
// apply (cells update, result registered) and hand-off of the result.
// One item is in flight at a time; s_tready stays low until the result is taken.
// rst_n clears the entry count and sequencer; table contents need no clearing.
// A stalled m_tready holds the result and the block.
`default_nettype none
module first_fit_page_region_allocator_top #(
    parameter int TABLE_DEPTH      = ffpra_pkg::TABLE_DEPTH_DEF,
    parameter int PAGE_NUMBER_BITS = ffpra_pkg::PAGE_NUMBER_BITS_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic s_tvalid,
    output logic      s_tready,
    // page_count [31:0], base_page above it, zero padded to bytes
    input  wire logic [((ffpra_pkg::COUNT_BITS+PAGE_NUMBER_BITS+7)/8)*8-1:0] s_tdata,
    // func [1:0]
    input  wire logic [1:0] s_tuser,
    output logic      m_tvalid,
    input  wire logic m_tready,
    // page_base, zero padded to bytes
    output logic [((PAGE_NUMBER_BITS+7)/8)*8-1:0] m_tdata,
    // status [1:0]
    output logic [1:0] m_tuser,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [63:0] pwdata,
    output logic      [63:0] prdata,
    output logic             pready
);
    localparam int PB = PAGE_NUMBER_BITS;
    localparam int CB = ffpra_pkg::COUNT_BITS;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int OW = ((PB + 7) / 8) * 8;

    ffpra_pkg::state_t state_reg, state_next;

    logic [PB-1:0]     pool_base_reg;
    logic [CB-1:0]     pool_pages_reg;
    logic [CW-1:0]     count_reg, count_next;
    ffpra_pkg::func_t  func_reg;
    logic [CB-1:0]     req_count_reg;
    logic [PB-1:0]     req_base_reg;
    ffpra_pkg::status_t status_reg, status_next;
    logic [PB-1:0]     pbase_reg, pbase_next;
    logic              out_valid_reg;

    ffpra_pkg::cell_ctl_t ctl;

    logic [PB-1:0] cell_base  [TABLE_DEPTH];
    logic [CB-1:0] cell_pages [TABLE_DEPTH];
    logic [CB-1:0] cell_rem   [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] hit, exact, pre, sel;
    logic [PB-1:0] sel_base;
    logic [CB-1:0] sel_rem;
    logic          sel_exact;
    logic          any_hit;

    // APB registers
    assign pready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pool_base_reg  <= '0;
            pool_pages_reg <= '0;
        end
        else if (psel && penable && pwrite)
        begin
            if (paddr[3])
                pool_pages_reg <= pwdata[CB-1:0];
            else
                pool_base_reg <= pwdata[PB-1:0];
        end
    end
    assign prdata = paddr[3] ? 64'(pool_pages_reg) : 64'(pool_base_reg);

    // Request capture
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            func_reg      <= ffpra_pkg::func_t'(s_tuser);
            req_count_reg <= s_tdata[CB-1:0];
            req_base_reg  <= s_tdata[CB+PB-1:CB];
        end
    end

    // First hit and its fields
    always_comb
    begin
        sel_base  = '0;
        sel_rem   = '0;
        sel_exact = 1'b0;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            pre[i] = hit[i] | ((i > 0) ? pre[(i > 0) ? i - 1 : 0] : 1'b0);
            sel[i] = hit[i] & ~((i > 0) ? pre[(i > 0) ? i - 1 : 0] : 1'b0);
            sel_base  = sel_base  | (sel[i] ? cell_base[i] : '0);
            sel_rem   = sel_rem   | (sel[i] ? cell_rem[i]  : '0);
            sel_exact = sel_exact | (sel[i] & exact[i]);
        end
        any_hit = pre[TABLE_DEPTH-1];
    end

    // Sequencer
    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        status_next = status_reg;
        pbase_next  = pbase_reg;
        ctl         = '0;
        ctl.is_alloc = (func_reg == ffpra_pkg::FUNC_ALLOC);
        case (state_reg)
            ffpra_pkg::S_IDLE:
            begin
                if (s_tvalid)
                    state_next = ffpra_pkg::S_SEARCH;
            end
            ffpra_pkg::S_SEARCH:
            begin
                ctl.search = 1'b1;
                state_next = ffpra_pkg::S_APPLY;
            end
            ffpra_pkg::S_APPLY:
            begin
                state_next  = ffpra_pkg::S_OUT;
                status_next = ffpra_pkg::ST_NOFIT;
                pbase_next  = '0;
                case (func_reg)
                    ffpra_pkg::FUNC_INIT:
                    begin
                        ctl.init    = 1'b1;
                        count_next  = CW'(1);
                        status_next = ffpra_pkg::ST_OK;
                    end
                    ffpra_pkg::FUNC_ALLOC:
                    begin
                        if (req_count_reg != '0 && any_hit)
                        begin
                            status_next = ffpra_pkg::ST_OK;
                            pbase_next  = sel_base;
                            if (sel_exact)
                            begin
                                ctl.remove = 1'b1;
                                count_next = count_reg - CW'(1);
                            end
                            else
                                ctl.cut = 1'b1;
                        end
                    end
                    ffpra_pkg::FUNC_MARK:
                    begin
                        if (req_count_reg == '0)
                            status_next = ffpra_pkg::ST_OK;
                        else if (any_hit)
                        begin
                            if (sel_exact)
                            begin
                                ctl.remove  = 1'b1;
                                count_next  = count_reg - CW'(1);
                                status_next = ffpra_pkg::ST_OK;
                            end
                            else if (count_reg >= CW'(TABLE_DEPTH))
                                status_next = ffpra_pkg::ST_FULL;
                            else
                            begin
                                ctl.split   = 1'b1;
                                count_next  = count_reg + CW'(1);
                                status_next = ffpra_pkg::ST_OK;
                            end
                        end
                    end
                    default:
                    begin
                        status_next = ffpra_pkg::ST_NOFIT;
                    end
                endcase
            end
            ffpra_pkg::S_OUT:
            begin
                if (m_tready)
                    state_next = ffpra_pkg::S_IDLE;
            end
            default:
            begin
                state_next = ffpra_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ffpra_pkg::S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= (state_next == ffpra_pkg::S_OUT);
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        pbase_reg  <= pbase_next;
    end

    assign s_tready = (state_reg == ffpra_pkg::S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OW'(pbase_reg);
    assign m_tuser  = status_reg;

    // Row of cells
    for (genvar i = 0; i < TABLE_DEPTH; i++)
    begin : g_cell
        logic [PB-1:0] nb;
        logic [CB-1:0] np;
        if (i < TABLE_DEPTH - 1)
        begin : g_mid
            assign nb = cell_base[i+1];
            assign np = cell_pages[i+1];
        end
        else
        begin : g_end
            assign nb = '0;
            assign np = '0;
        end

        ffpra_cell #(
            .PB (PB)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctl        (ctl),
            .in_use     (CW'(i) < count_reg),
            .head       (i == 0),
            .sel        (sel[i]),
            .shift      (pre[i] && (CW'(i + 1) < count_reg)),
            .append     (CW'(i) == count_reg),
            .req_base   (req_base_reg),
            .req_count  (req_count_reg),
            .pool_base  (pool_base_reg),
            .pool_pages (pool_pages_reg),
            .nxt_base   (nb),
            .nxt_pages  (np),
            .app_pages  (sel_rem),
            .base       (cell_base[i]),
            .pages      (cell_pages[i]),
            .hit        (hit[i]),
            .exact      (exact[i]),
            .rem        (cell_rem[i])
        );
    end
endmodule
`default_nettype wire

@@ design/ffpra_checker.sv @@
// Port-level checks for the first-fit page region allocator, bound to the top level.
// Depends on first_fit_page_region_allocator_top.
`default_nettype none
module ffpra_checker (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic s_tvalid,
    input wire logic s_tready,
    input wire logic m_tvalid,
    input wire logic m_tready,
    input wire logic [1:0] m_tuser
);
    // one item at a time: no accept right after an accept
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted while an item is in flight");

    // result appears once the item has passed the search and apply states
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |-> ##3 m_tvalid)
        else $error("result not presented on time");

    // no input is taken while a result waits
    a_block: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !s_tready)
        else $error("input ready while result pending");

    // stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tuser)))
        else $error("stalled result changed");
endmodule

bind first_fit_page_region_allocator_top ffpra_checker u_ffpra_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tuser  (m_tuser)
);
`default_nettype wire
